// ===== src/pcb_pkg.sv =====
`timescale 1ns / 1ps

package pcb_pkg;

  localparam int unsigned VOLT_W   = 16;
  localparam int unsigned DUTY_W   = 4;
  localparam int unsigned SEG_W    = 2;
  localparam int unsigned CEL_W    = 4;
  localparam int unsigned MAX_SEGS = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CODE           = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNDERVOLTAGE_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_THRESHOLD = 2'd2;

  localparam logic [VOLT_W-1:0] UV_LIMIT_RST  = 16'd25000;
  localparam logic [VOLT_W-1:0] THRESHOLD_RST = 16'd100;

  typedef logic [VOLT_W-1:0]   volt_t;
  typedef logic [DUTY_W-1:0]   duty_t;
  typedef logic [SEG_W-1:0]    seg_t;
  typedef logic [MAX_SEGS-1:0] seg_mask_t;

  typedef struct packed {
    volt_t cell_voltage;
    logic  cell_valid;
  } in_item_t;

  typedef struct packed {
    duty_t duty;
    logic  last_duty;
  } out_item_t;

  typedef struct packed {
    duty_t duty_code;
    volt_t undervoltage_limit;
    volt_t discharge_threshold;
  } cfg_t;

  // Scan summary gathered while the cells load.
  typedef struct packed {
    volt_t     lowest;
    logic      any_valid;
    seg_mask_t seg_ok;
  } scan_stat_t;

  // Describes the voltage sitting in the memory's read register.
  typedef struct packed {
    logic valid;
    seg_t seg;
    logic last;
  } rd_tag_t;

endpackage

// ===== src/pcb_cell_mem.sv =====
`timescale 1ns / 1ps

module pcb_cell_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  pcb_pkg::volt_t      wdata_i,
  input  logic                re_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  output pcb_pkg::volt_t      rdata_o
);

  pcb_pkg::volt_t mem_q [DEPTH];
  pcb_pkg::volt_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // The read register only moves on a read, so a stalled entry holds.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pcb_ctrl.sv =====
`timescale 1ns / 1ps

module pcb_ctrl #(
  parameter int unsigned CELLS_PER_SEG = 16,
  parameter int unsigned TOTAL         = 64,
  parameter int unsigned ADDR_W        = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pcb_pkg::in_item_t     in_item_i,
  output logic                  mem_we_o,
  output logic                  mem_re_o,
  output logic [ADDR_W-1:0]     mem_addr_o,
  input  logic                  take_i,
  input  logic                  done_i,
  output pcb_pkg::rd_tag_t      rd_tag_o,
  output pcb_pkg::scan_stat_t   stat_o
);

  typedef enum logic {
    PH_LOAD,
    PH_EMIT
  } phase_e;

  localparam logic [ADDR_W-1:0]         LastPos = ADDR_W'(TOTAL - 1);
  localparam logic [pcb_pkg::CEL_W-1:0] LastCel = pcb_pkg::CEL_W'(CELLS_PER_SEG - 1);

  phase_e                  phase_q, phase_d;
  logic [ADDR_W-1:0]       pos_q, pos_d;
  pcb_pkg::seg_t           seg_q, seg_d;
  logic [pcb_pkg::CEL_W-1:0] cel_q, cel_d;
  logic                    issued_all_q, issued_all_d;
  pcb_pkg::rd_tag_t        tag_q, tag_d;
  pcb_pkg::scan_stat_t     stat_q, stat_d;

  logic in_acc;
  logic issue;
  logic at_last;

  assign in_stall_o = (phase_q != PH_LOAD);
  assign in_acc     = in_valid_i && (phase_q == PH_LOAD);
  assign issue      = (phase_q == PH_EMIT) && !issued_all_q && (!tag_q.valid || take_i);
  assign at_last    = (pos_q == LastPos);

  assign mem_we_o   = in_acc;
  assign mem_re_o   = issue;
  assign mem_addr_o = pos_q;
  assign rd_tag_o   = tag_q;
  assign stat_o     = stat_q;

  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    seg_d        = seg_q;
    cel_d        = cel_q;
    issued_all_d = issued_all_q;
    tag_d        = tag_q;
    stat_d       = stat_q;

    // One counter step is shared by loading and emitting.
    if (in_acc || issue) begin
      if (at_last) begin
        pos_d = '0;
        seg_d = '0;
        cel_d = '0;
      end else begin
        pos_d = pos_q + ADDR_W'(1);
        if (cel_q == LastCel) begin
          cel_d = '0;
          seg_d = seg_q + pcb_pkg::SEG_W'(1);
        end else begin
          cel_d = cel_q + pcb_pkg::CEL_W'(1);
        end
      end
    end

    if (in_acc) begin
      if (in_item_i.cell_valid) begin
        stat_d.any_valid = 1'b1;
        if (in_item_i.cell_voltage < stat_q.lowest) begin
          stat_d.lowest = in_item_i.cell_voltage;
        end
      end else begin
        stat_d.seg_ok[seg_q] = 1'b0;
      end
      if (at_last) begin
        phase_d = PH_EMIT;
      end
    end

    if (issue) begin
      tag_d.valid = 1'b1;
      tag_d.seg   = seg_q;
      tag_d.last  = at_last;
      if (at_last) begin
        issued_all_d = 1'b1;
      end
    end else if (take_i) begin
      tag_d.valid = 1'b0;
    end

    // Final transfer of the scan: return to loading and clear the summary for the next one.
    if (done_i) begin
      phase_d          = PH_LOAD;
      issued_all_d     = 1'b0;
      stat_d.lowest    = '1;
      stat_d.any_valid = 1'b0;
      stat_d.seg_ok    = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_LOAD;
      pos_q            <= '0;
      seg_q            <= '0;
      cel_q            <= '0;
      issued_all_q     <= 1'b0;
      tag_q            <= '0;
      stat_q.lowest    <= '1;
      stat_q.any_valid <= 1'b0;
      stat_q.seg_ok    <= '1;
    end else begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      seg_q        <= seg_d;
      cel_q        <= cel_d;
      issued_all_q <= issued_all_d;
      tag_q        <= tag_d;
      stat_q       <= stat_d;
    end
  end

endmodule

// ===== src/pcb_duty_out.sv =====
`timescale 1ns / 1ps

module pcb_duty_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pcb_pkg::cfg_t        cfg_i,
  input  pcb_pkg::scan_stat_t  stat_i,
  input  pcb_pkg::rd_tag_t     rd_tag_i,
  input  pcb_pkg::volt_t       rdata_i,
  output logic                 take_o,
  output logic                 done_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pcb_pkg::out_item_t   out_item_o
);

  logic               out_valid_q;
  pcb_pkg::out_item_t out_item_q;
  pcb_pkg::out_item_t out_item_d;
  pcb_pkg::volt_t     excess;
  logic               balance;
  logic               out_free;

  assign excess  = rdata_i - stat_i.lowest;
  assign balance = (cfg_i.duty_code != '0) && stat_i.any_valid &&
                   stat_i.seg_ok[rd_tag_i.seg] &&
                   (rdata_i > cfg_i.undervoltage_limit) &&
                   (rdata_i >= stat_i.lowest) &&
                   (excess >= cfg_i.discharge_threshold);

  always_comb begin
    out_item_d.duty      = balance ? cfg_i.duty_code : '0;
    out_item_d.last_duty = rd_tag_i.last;
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign take_o   = rd_tag_i.valid && out_free;
  assign done_o   = out_valid_q && !out_stall_i && out_item_q.last_duty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= rd_tag_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== src/passive_cell_balance_duty.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  in_item_i   (cell_voltage, cell_valid)
// out      output     out_valid_o/out_stall_i out_item_o (duty, last_duty)
// cfg      input      cfg_we_i               cfg_index_i, cfg_data_i
//
// A scan loads at one cell per cycle into the voltage memory; the input stalls
// from the last cell's transfer until the final duty of the scan is taken.
// The emit pass reads one stored voltage per cycle through the memory's single
// read port while the output is not stalled, so a scan of N cells delivers N
// duties once the last cell is in, one a cycle while the output is not stalled.
// Reset clears control and the scan summary; the memory itself is not cleared.

module passive_cell_balance_duty #(
  parameter int unsigned SEGMENTS      = 4,
  parameter int unsigned CELLS_PER_SEG = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  pcb_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pcb_pkg::out_item_t                out_item_o,
  input  logic                              cfg_we_i,
  input  logic [pcb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pcb_pkg::VOLT_W-1:0]        cfg_data_i
);

  localparam int unsigned TOTAL  = SEGMENTS * CELLS_PER_SEG;
  localparam int unsigned ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;

  pcb_pkg::cfg_t       cfg_q;
  pcb_pkg::scan_stat_t stat;
  pcb_pkg::rd_tag_t    rd_tag;
  pcb_pkg::volt_t      rdata;
  logic                mem_we;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_addr;
  logic                take;
  logic                done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_code           <= '0;
      cfg_q.undervoltage_limit  <= pcb_pkg::UV_LIMIT_RST;
      cfg_q.discharge_threshold <= pcb_pkg::THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pcb_pkg::CFG_DUTY_CODE:
          cfg_q.duty_code <= cfg_data_i[pcb_pkg::DUTY_W-1:0];
        pcb_pkg::CFG_UNDERVOLTAGE_LIMIT:
          cfg_q.undervoltage_limit <= cfg_data_i;
        pcb_pkg::CFG_DISCHARGE_THRESHOLD:
          cfg_q.discharge_threshold <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  pcb_ctrl #(
    .CELLS_PER_SEG (CELLS_PER_SEG),
    .TOTAL         (TOTAL),
    .ADDR_W        (ADDR_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .mem_we_o   (mem_we),
    .mem_re_o   (mem_re),
    .mem_addr_o (mem_addr),
    .take_i     (take),
    .done_i     (done),
    .rd_tag_o   (rd_tag),
    .stat_o     (stat)
  );

  pcb_cell_mem #(
    .DEPTH  (TOTAL),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (in_item_i.cell_voltage),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (rdata)
  );

  pcb_duty_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .stat_i      (stat),
    .rd_tag_i    (rd_tag),
    .rdata_i     (rdata),
    .take_o      (take),
    .done_o      (done),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== src/pcb_checker.sv =====
`timescale 1ns / 1ps

module pcb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input pcb_pkg::out_item_t out_item_o
);

  // No cell is taken while duties of the previous scan are still pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while duties are pending");

  // The final duty of a scan reopens the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_item_o.last_duty) |=> !in_stall_o)
    else $error("input still stalled after the final duty");

  // Within a scan the duties stream without gaps once started.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_item_o.last_duty) |=> out_valid_o)
    else $error("gap in the duty stream");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

endmodule

bind passive_cell_balance_duty pcb_checker u_pcb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned SEGS       = 4;
  localparam int unsigned SEG_CELLS  = 16;
  localparam int unsigned NCELLS     = SEGS * SEG_CELLS;
  localparam int unsigned RAND_SCANS = 1;

  // Index past the register list; the block must ignore writes to it.
  localparam logic [pcb_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {
    PAT_EXTREMES,
    PAT_BOUNDARY,
    PAT_RANDOM
  } pattern_e;

  typedef struct {
    bit             write_cfg;
    pcb_pkg::duty_t duty;
    pcb_pkg::volt_t uv;
    pcb_pkg::volt_t thr;
    pattern_e       pat;
    bit             all_zero;
  } scan_row_t;

  // Rows marked all_zero carry their expected duties directly: every cell gets 0.
  scan_row_t scan_plan [2] = '{
    '{1'b0, 4'd0,  16'd0,     16'd0,     PAT_EXTREMES, 1'b1},
    '{1'b1, 4'd9,  16'd2000,  16'd100,   PAT_BOUNDARY, 1'b0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  pcb_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  pcb_pkg::out_item_t out_item_o;
  logic               cfg_we_i;
  logic [pcb_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [pcb_pkg::VOLT_W-1:0]    cfg_data_i;

  // Register copies and scan summary of the balancing predictor.
  pcb_pkg::duty_t duty_code_r = '0;
  pcb_pkg::volt_t uv_limit_r  = pcb_pkg::UV_LIMIT_RST;
  pcb_pkg::volt_t threshold_r = pcb_pkg::THRESHOLD_RST;
  pcb_pkg::volt_t volt_mem [NCELLS];
  bit             seg_whole [SEGS] = '{default: 1'b1};
  pcb_pkg::volt_t lowest_seen = '1;
  bit             seen_valid = 1'b0;
  int unsigned    scan_pos = 0;
  pcb_pkg::duty_t duty_pred [NCELLS];

  pcb_pkg::out_item_t duty_expected [$];
  pcb_pkg::out_item_t duty_head;
  int unsigned fails = 0;
  bit          no_gaps = 1'b0;
  int unsigned rand_base = 30000;
  int unsigned rand_mode = 0;

  passive_cell_balance_duty #(
    .SEGMENTS      (SEGS),
    .CELLS_PER_SEG (SEG_CELLS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(string what);
    if (fails < 30) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
    fails++;
  endtask

  // Takes one cell into the scan; on the last cell it fills duty_pred and
  // starts a fresh scan summary.
  function automatic bit take_cell(pcb_pkg::in_item_t c);
    int unsigned seg;
    pcb_pkg::volt_t v;
    seg = scan_pos / SEG_CELLS;
    volt_mem[scan_pos] = c.cell_voltage;
    if (c.cell_valid) begin
      seen_valid = 1'b1;
      if (c.cell_voltage < lowest_seen) begin
        lowest_seen = c.cell_voltage;
      end
    end else begin
      seg_whole[seg] = 1'b0;
    end
    if (scan_pos + 1 < NCELLS) begin
      scan_pos++;
      return 1'b0;
    end
    for (int k = 0; k < NCELLS; k++) begin
      v = volt_mem[k];
      duty_pred[k] = '0;
      if (duty_code_r != '0 && seen_valid && seg_whole[k / SEG_CELLS] &&
          v > uv_limit_r && v >= lowest_seen &&
          pcb_pkg::volt_t'(v - lowest_seen) >= threshold_r) begin
        duty_pred[k] = duty_code_r;
      end
    end
    seg_whole = '{default: 1'b1};
    lowest_seen = '1;
    seen_valid = 1'b0;
    scan_pos = 0;
    return 1'b1;
  endfunction

  task automatic write_reg(logic [pcb_pkg::CFG_IDX_W-1:0] idx,
                           logic [pcb_pkg::VOLT_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    unique case (idx)
      pcb_pkg::CFG_DUTY_CODE:           duty_code_r = pcb_pkg::duty_t'(data);
      pcb_pkg::CFG_UNDERVOLTAGE_LIMIT:  uv_limit_r  = data;
      pcb_pkg::CFG_DISCHARGE_THRESHOLD: threshold_r = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_regs(pcb_pkg::duty_t duty, pcb_pkg::volt_t uv, pcb_pkg::volt_t thr);
    write_reg(pcb_pkg::CFG_DUTY_CODE, {12'($urandom), duty});
    write_reg(pcb_pkg::CFG_UNDERVOLTAGE_LIMIT, uv);
    write_reg(pcb_pkg::CFG_DISCHARGE_THRESHOLD, thr);
    write_reg(CFG_UNUSED, 16'($urandom));
  endtask

  function automatic pcb_pkg::in_item_t make_cell(pattern_e pat, int unsigned k);
    pcb_pkg::in_item_t c;
    c.cell_valid = 1'b1;
    unique case (pat)
      PAT_EXTREMES: begin
        unique case (k % 4)
          0:       c.cell_voltage = 16'h0000;
          1:       c.cell_voltage = 16'hFFFF;
          2:       c.cell_voltage = 16'h5555;
          default: c.cell_voltage = 16'hAAAA;
        endcase
      end
      PAT_BOUNDARY: begin
        unique case (k % 6)
          0:       c.cell_voltage = 16'd1999;
          1:       c.cell_voltage = 16'd2000;
          2:       c.cell_voltage = 16'd2001;
          3:       c.cell_voltage = 16'd2499;
          4:       c.cell_voltage = 16'd2500;
          default: c.cell_voltage = 16'd2501;
        endcase
        if (k == 0) begin
          c.cell_voltage = 16'd1000;
        end
      end
      default: begin
        if (rand_mode == 2) begin
          c.cell_voltage = pcb_pkg::volt_t'($urandom);
          c.cell_valid   = 1'($urandom_range(0, 1));
        end else begin
          c.cell_voltage = pcb_pkg::volt_t'(rand_base + $urandom_range(0, 3000));
          c.cell_valid   = (rand_mode == 0) || ($urandom_range(0, 40) != 0);
        end
      end
    endcase
    return c;
  endfunction

  task automatic send_cell(pcb_pkg::in_item_t c, bit all_zero);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
    if (take_cell(c)) begin
      for (int k = 0; k < NCELLS; k++) begin
        duty_head.duty      = all_zero ? pcb_pkg::duty_t'(0) : duty_pred[k];
        duty_head.last_duty = (k == NCELLS - 1);
        duty_expected.push_back(duty_head);
      end
    end
  endtask

  task automatic run_scan(pattern_e pat, bit all_zero);
    for (int k = 0; k < NCELLS; k++) begin
      send_cell(make_cell(pat, k), all_zero);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (duty_expected.size() == 0);
    // The emit pass may still be winding down after the final duty.
    repeat (8) @(posedge clk_i);
  endtask

  function automatic pcb_pkg::volt_t pick_level(int unsigned near, int unsigned spread);
    unique case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return pcb_pkg::volt_t'(near + $urandom_range(0, spread));
    endcase
  endfunction

  initial begin
    pcb_pkg::duty_t duty;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = pcb_pkg::CFG_DUTY_CODE;
    cfg_data_i  = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (scan_plan[i]) begin
      if (scan_plan[i].write_cfg) begin
        write_regs(scan_plan[i].duty, scan_plan[i].uv, scan_plan[i].thr);
      end
      no_gaps = (i % 2 == 1);
      run_scan(scan_plan[i].pat, scan_plan[i].all_zero);
    end

    for (int s = 0; s < RAND_SCANS; s++) begin
      rand_base = $urandom_range(30000, 40000);
      rand_mode = $urandom_range(0, 5) == 5 ? 2 : $urandom_range(0, 1);
      unique case ($urandom_range(0, 3))
        0:       duty = 4'd0;
        1:       duty = 4'd15;
        default: duty = pcb_pkg::duty_t'($urandom);
      endcase
      write_regs(duty, pick_level(rand_base - 1000, 4000), pick_level(0, 2500));
      no_gaps = ($urandom_range(0, 3) == 0);
      run_scan(PAT_RANDOM, 1'b0);
    end

    if (fails == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Output back-pressure: a random stall, possibly none, ahead of each transfer unless no_gaps is set.
  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 3);
      repeat (hold) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (duty_expected.size() == 0) begin
        report_mismatch($sformatf("duty %0d arrived with none expected", out_item_o.duty));
      end else begin
        duty_head = duty_expected.pop_front();
        if (out_item_o.duty !== duty_head.duty) begin
          report_mismatch($sformatf("duty %0d, expected %0d",
                                    out_item_o.duty, duty_head.duty));
        end
        if (out_item_o.last_duty !== duty_head.last_duty) begin
          report_mismatch($sformatf("last_duty %0b, expected %0b",
                                    out_item_o.last_duty, duty_head.last_duty));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
